// File: src/u2u8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types, constants and the per-unit encoder of the UTF-16 to UTF-8
// converter.
// ----------------------------------------------------------------------------
package u2u8_pkg;

  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
  localparam logic [15:0] ONE_BYTE_MAX  = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX  = 16'h07FF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;

  localparam int unsigned MAX_BYTES = 6;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  // Bytes of one job, first byte in slot 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      last;
  } job_t;

  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      n;
  } enc_t;

  function automatic enc_t encode_unit(input logic [15:0] c);
    enc_t e;
    e = '0;
    if (c <= ONE_BYTE_MAX) begin
      e.b[0] = c[7:0];
      e.n    = 2'd1;
    end else if (c <= TWO_BYTE_MAX) begin
      e.b[0] = {3'b110, c[10:6]};
      e.b[1] = {2'b10, c[5:0]};
      e.n    = 2'd2;
    end else begin
      e.b[0] = {4'b1110, c[15:12]};
      e.b[1] = {2'b10, c[11:6]};
      e.b[2] = {2'b10, c[5:0]};
      e.n    = 2'd3;
    end
    return e;
  endfunction

endpackage

// File: src/u2u8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_front
// Accepts code units, pairs surrogates and turns each unit that is not held
// into a job of up to six UTF-8 bytes for the byte queue.
// ----------------------------------------------------------------------------
module u2u8_front
  import u2u8_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     queue_full,
  output logic     push,
  output job_t     push_job
);

  logic       pending_valid;
  logic [9:0] pending_high;
  logic       pending_valid_next;
  logic [9:0] pending_high_next;

  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       hold_now;
  logic [20:0] pair_cp;
  enc_t       held_enc;
  enc_t       unit_enc;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign is_high  = (in_item.code_unit >= HIGH_SURR_MIN) && (in_item.code_unit <= HIGH_SURR_MAX);
  assign is_low   = (in_item.code_unit >= LOW_SURR_MIN) && (in_item.code_unit <= LOW_SURR_MAX);
  assign hold_now = is_high && !in_item.unit_last;

  assign held_enc = encode_unit({HIGH_SURR_TAG, pending_high});
  assign unit_enc = encode_unit(in_item.code_unit);
  assign pair_cp  = {1'b0, pending_high, in_item.code_unit[9:0]} + SUPP_BASE;

  always_comb begin
    push_job      = '0;
    push_job.last = in_item.unit_last;
    if (pending_valid && is_low) begin
      push_job.bytes[0] = {5'b11110, pair_cp[20:18]};
      push_job.bytes[1] = {2'b10, pair_cp[17:12]};
      push_job.bytes[2] = {2'b10, pair_cp[11:6]};
      push_job.bytes[3] = {2'b10, pair_cp[5:0]};
      push_job.count    = 3'd4;
    end else if (pending_valid) begin
      // The held surrogate goes out alone; the unit follows unless held.
      for (int k = 0; k < 3; k++) begin
        push_job.bytes[k] = held_enc.b[k];
      end
      if (hold_now) begin
        push_job.count = 3'd3;
      end else begin
        for (int k = 0; k < 3; k++) begin
          push_job.bytes[k+3] = unit_enc.b[k];
        end
        push_job.count = 3'd3 + {1'b0, unit_enc.n};
      end
    end else if (!hold_now) begin
      for (int k = 0; k < 3; k++) begin
        push_job.bytes[k] = unit_enc.b[k];
      end
      push_job.count = {1'b0, unit_enc.n};
    end
  end

  assign push = accept && (push_job.count != 3'd0);

  always_comb begin
    pending_valid_next = pending_valid;
    pending_high_next  = pending_high;
    if (accept) begin
      if (hold_now && !(pending_valid && is_low)) begin
        pending_valid_next = 1'b1;
        pending_high_next  = in_item.code_unit[9:0];
      end else begin
        pending_valid_next = 1'b0;
        pending_high_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_high  <= '0;
    end else begin
      pending_valid <= pending_valid_next;
      pending_high  <= pending_high_next;
    end
  end

  a_last_clears_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.unit_last) |=> !pending_valid)
    else $error("held surrogate survived the last unit of a string");

  a_hold_no_push: assert property (@(posedge clk) disable iff (rst)
    (accept && hold_now && !pending_valid) |-> !push)
    else $error("a held high surrogate produced bytes");

endmodule

// File: src/u2u8_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_queue
// Short queue of byte jobs between the front and the byte serializer.
// ----------------------------------------------------------------------------
module u2u8_queue
  import u2u8_pkg::*;
#(
  parameter int unsigned DEPTH = 2
)
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_FULL);
  assign avail    = (fill != '0);
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && avail) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && avail})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: src/u2u8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_back
// Takes byte jobs from the queue and sends their bytes out one per transfer.
// ----------------------------------------------------------------------------
module u2u8_back
  import u2u8_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_avail,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic       busy;
  job_t       cur;
  logic [2:0] idx;
  logic       last_byte;
  logic       done;

  assign out_valid = busy;
  assign last_byte = (idx == cur.count - 3'd1);
  assign done      = busy && out_ready && last_byte;
  // The next job is loaded in the same cycle as the final byte's transfer.
  assign pop       = job_avail && (!busy || done);

  assign out_item.out_byte   = cur.bytes[idx];
  assign out_item.run_last   = last_byte;
  assign out_item.string_end = last_byte && cur.last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (done) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (busy && out_ready) begin
      idx <= idx + 3'd1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cur.count != 3'd0) && (cur.count <= 3'(MAX_BYTES)))
    else $error("job with an impossible byte count");

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < cur.count))
    else $error("byte index ran past the job");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_item.run_last) |=> out_valid)
    else $error("run of bytes broken before its last byte");

endmodule

// File: src/utf16_to_utf8_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_converter
// Streaming UTF-16 to UTF-8 encoder: one code unit in, up to six bytes out.
//
//   channel | direction | payload     | handshake
//   in      | input     | in_item_t   | in_valid / in_ready
//   out     | output    | out_item_t  | out_valid / out_ready
//
// A unit is taken whenever the job queue has room; the front
// end encodes it combinationally and queues its bytes as one job.
// The output sends one byte per cycle while out_ready is high and a job is
// loaded. A unit gives 1 to 3 bytes, 4 for a surrogate pair, up to 6 when a
// held surrogate is flushed. A held high surrogate produces no output byte.
// Reset clears the held surrogate, the queue and the serializer.
// A stalled output fills the queue (FIFO_DEPTH jobs) and then drops in_ready.
// ----------------------------------------------------------------------------
module utf16_to_utf8_converter
  import u2u8_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 2
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic push;
  job_t push_job;
  logic queue_full;
  logic pop;
  logic job_avail;
  job_t head_job;

  u2u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  u2u8_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .avail    (job_avail),
    .head_job (head_job)
  );

  u2u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (job_avail),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
